// File: hw/rtl/rrts_pkg.sv
// Shared types, constants and helper functions of the round-robin thread scheduler.
package rrts_pkg;

    localparam int DEF_MAX_THREADS = 16;
    localparam int FUNC_W          = 3;
    localparam int TID_W           = 4;
    localparam int STATUS_W        = 3;
    localparam int VALUE_W         = 32;
    localparam int QLEN_W          = 20;
    localparam logic [QLEN_W-1:0] DEF_QUANTUM = 20'd1000;

    typedef enum logic [FUNC_W-1:0] {
        FN_TICK   = 3'd0,
        FN_SPAWN  = 3'd1,
        FN_TERM   = 3'd2,
        FN_BLOCK  = 3'd3,
        FN_RESUME = 3'd4,
        FN_LOCK   = 3'd5,
        FN_UNLOCK = 3'd6,
        FN_QUERY  = 3'd7
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_NO_THREAD = 3'd1,
        ST_FULL      = 3'd2,
        ST_MAIN_BLK  = 3'd3,
        ST_RELOCK    = 3'd4,
        ST_BAD_UNLK  = 3'd5,
        ST_SHUTDOWN  = 3'd6
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_DQ,
        S_SW_ENQ,
        S_SW_RD,
        S_SW_POP,
        S_SW_INC,
        S_QDATA,
        S_DONE
    } t_state;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_ACCEPT,
        CMD_DECODE,
        CMD_SCAN,
        CMD_DQ,
        CMD_SW_ENQ,
        CMD_SW_RD,
        CMD_SW_POP,
        CMD_SW_INC,
        CMD_QDATA,
        CMD_FINISH
    } t_cmd;

    typedef struct packed {
        t_func func;
        logic  bad;
        logic  tid_zero;
        logic  expire;
        logic  held;
        logic  owner_cur;
        logic  queued_tid;
        logic  cur_tid;
        logic  scan_stop;
        logic  dq_done;
    } t_dp_status;

    function automatic logic [QLEN_W-1:0] reload(input logic [QLEN_W-1:0] len);
        reload = (len == '0) ? QLEN_W'(1) : len;
    endfunction

    function automatic logic [VALUE_W-1:0] sat_inc(input logic [VALUE_W-1:0] v);
        sat_inc = (v == '1) ? v : v + VALUE_W'(1);
    endfunction

endpackage

// File: hw/rtl/rrts_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rrts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/rrts_ctrl.sv
// Controller state machine that sequences each scheduler command.
module rrts_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  rrts_pkg::t_dp_status   i_stat,
    output rrts_pkg::t_cmd         o_cmd,
    output logic                   o_busy
);

    rrts_pkg::t_state r_state;
    rrts_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rrts_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = rrts_pkg::CMD_NONE;
        unique case (r_state)
            rrts_pkg::S_IDLE: begin
                if (i_start) begin
                    o_cmd   = rrts_pkg::CMD_ACCEPT;
                    n_state = rrts_pkg::S_DECODE;
                end
            end
            rrts_pkg::S_DECODE: begin
                o_cmd   = rrts_pkg::CMD_DECODE;
                n_state = rrts_pkg::S_DONE;
                unique case (i_stat.func)
                    rrts_pkg::FN_TICK: begin
                        if (i_stat.expire) begin
                            n_state = rrts_pkg::S_SW_ENQ;
                        end
                    end
                    rrts_pkg::FN_SPAWN: begin
                        n_state = rrts_pkg::S_SCAN;
                    end
                    rrts_pkg::FN_TERM: begin
                        priority if (i_stat.bad || i_stat.tid_zero) begin
                            n_state = rrts_pkg::S_DONE;
                        end else if (i_stat.queued_tid) begin
                            n_state = rrts_pkg::S_DQ;
                        end else if (i_stat.cur_tid) begin
                            n_state = rrts_pkg::S_SW_RD;
                        end else begin
                            n_state = rrts_pkg::S_DONE;
                        end
                    end
                    rrts_pkg::FN_BLOCK: begin
                        priority if (i_stat.bad || i_stat.tid_zero) begin
                            n_state = rrts_pkg::S_DONE;
                        end else if (i_stat.queued_tid) begin
                            n_state = rrts_pkg::S_DQ;
                        end else if (i_stat.cur_tid) begin
                            n_state = rrts_pkg::S_SW_ENQ;
                        end else begin
                            n_state = rrts_pkg::S_DONE;
                        end
                    end
                    rrts_pkg::FN_RESUME: begin
                        n_state = rrts_pkg::S_DONE;
                    end
                    rrts_pkg::FN_LOCK: begin
                        if (i_stat.held && !i_stat.owner_cur) begin
                            n_state = rrts_pkg::S_SW_ENQ;
                        end
                    end
                    rrts_pkg::FN_UNLOCK: begin
                        if (i_stat.held && i_stat.owner_cur) begin
                            n_state = rrts_pkg::S_SCAN;
                        end
                    end
                    rrts_pkg::FN_QUERY: begin
                        if (!i_stat.bad) begin
                            n_state = rrts_pkg::S_QDATA;
                        end
                    end
                    default: begin
                        n_state = rrts_pkg::S_DONE;
                    end
                endcase
            end
            rrts_pkg::S_SCAN: begin
                o_cmd = rrts_pkg::CMD_SCAN;
                if (i_stat.scan_stop) begin
                    n_state = rrts_pkg::S_DONE;
                end
            end
            rrts_pkg::S_DQ: begin
                o_cmd = rrts_pkg::CMD_DQ;
                if (i_stat.dq_done) begin
                    priority if (!i_stat.cur_tid) begin
                        n_state = rrts_pkg::S_DONE;
                    end else if (i_stat.func == rrts_pkg::FN_TERM) begin
                        n_state = rrts_pkg::S_SW_RD;
                    end else begin
                        n_state = rrts_pkg::S_SW_ENQ;
                    end
                end
            end
            rrts_pkg::S_SW_ENQ: begin
                o_cmd   = rrts_pkg::CMD_SW_ENQ;
                n_state = rrts_pkg::S_SW_RD;
            end
            rrts_pkg::S_SW_RD: begin
                o_cmd   = rrts_pkg::CMD_SW_RD;
                n_state = rrts_pkg::S_SW_POP;
            end
            rrts_pkg::S_SW_POP: begin
                o_cmd   = rrts_pkg::CMD_SW_POP;
                n_state = rrts_pkg::S_SW_INC;
            end
            rrts_pkg::S_SW_INC: begin
                o_cmd   = rrts_pkg::CMD_SW_INC;
                n_state = rrts_pkg::S_DONE;
            end
            rrts_pkg::S_QDATA: begin
                o_cmd   = rrts_pkg::CMD_QDATA;
                n_state = rrts_pkg::S_DONE;
            end
            rrts_pkg::S_DONE: begin
                o_cmd   = rrts_pkg::CMD_FINISH;
                n_state = rrts_pkg::S_IDLE;
            end
            default: begin
                n_state = rrts_pkg::S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != rrts_pkg::S_IDLE);

`ifndef SYNTH
    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rrts_pkg::S_DONE) |=> (r_state == rrts_pkg::S_IDLE))
        else $error("finish state not followed by idle");
    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd == rrts_pkg::CMD_ACCEPT) |=> (r_state == rrts_pkg::S_DECODE))
        else $error("accepted transaction not decoded");
    a_scan_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rrts_pkg::S_SCAN && i_stat.scan_stop) |=> (r_state == rrts_pkg::S_DONE))
        else $error("scan did not finish");
`endif

endmodule

// File: hw/rtl/rrts_datapath.sv
// Datapath holding thread flags, ready queue, quanta store, mutex and tick counter.
module rrts_datapath #(
    parameter int MAX_THREADS = rrts_pkg::DEF_MAX_THREADS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rrts_pkg::t_cmd                i_cmd,
    output rrts_pkg::t_dp_status          o_stat,
    input  logic [rrts_pkg::FUNC_W-1:0]   i_func,
    input  logic [rrts_pkg::TID_W-1:0]    i_tid,
    input  logic                          i_cfg_we,
    input  logic [rrts_pkg::QLEN_W-1:0]   i_cfg_wdata,
    output logic [rrts_pkg::STATUS_W-1:0] o_status,
    output logic [rrts_pkg::VALUE_W-1:0]  o_value,
    output logic [rrts_pkg::TID_W-1:0]    o_running_id,
    output logic [rrts_pkg::VALUE_W-1:0]  o_total_quanta,
    output logic                          o_switched,
    output logic                          o_done
);

    localparam int ID_W  = $clog2(MAX_THREADS);
    localparam int CNT_W = ID_W + 1;
    localparam int SUM_W = ID_W + 2;
    localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_THREADS);
    localparam logic [SUM_W-1:0] MAX_SUM  = SUM_W'(MAX_THREADS);
    localparam logic [ID_W-1:0]  LAST_ID  = ID_W'(MAX_THREADS - 1);
    localparam int VW = rrts_pkg::VALUE_W;

    rrts_pkg::t_func               r_func,      n_func;
    logic [rrts_pkg::TID_W-1:0]    r_tid,       n_tid;
    logic [MAX_THREADS-1:0]        r_exists,    n_exists;
    logic [MAX_THREADS-1:0]        r_blocked,   n_blocked;
    logic [MAX_THREADS-1:0]        r_waiting,   n_waiting;
    logic [MAX_THREADS-1:0]        r_queued,    n_queued;
    logic [MAX_THREADS-1:0]        r_qvalid,    n_qvalid;
    logic [ID_W-1:0]               r_head,      n_head;
    logic [CNT_W-1:0]              r_cnt,       n_cnt;
    logic                          r_held,      n_held;
    logic [ID_W-1:0]               r_owner,     n_owner;
    logic [ID_W-1:0]               r_cur,       n_cur;
    logic [VW-1:0]                 r_total,     n_total;
    logic [rrts_pkg::QLEN_W-1:0]   r_countdown, n_countdown;
    logic [rrts_pkg::QLEN_W-1:0]   r_qlen,      n_qlen;
    logic [CNT_W-1:0]              r_scan,      n_scan;
    logic [ID_W-1:0]               r_rd_ptr,    n_rd_ptr;
    logic [ID_W-1:0]               r_wr_ptr,    n_wr_ptr;
    logic [CNT_W-1:0]              r_k,         n_k;
    logic [CNT_W-1:0]              r_j,         n_j;
    logic                          r_pend,      n_pend;
    rrts_pkg::t_status             r_status,    n_status;
    logic [VW-1:0]                 r_value,     n_value;
    logic                          r_sw,        n_sw;
    logic                          r_done,      n_done;
    logic                          r_qv_ok,     r_q_is0;

    logic [ID_W-1:0]  tid_idx, scan_idx, c_new, tail, head_inc, rd_inc, wr_inc, enq_id;
    logic [SUM_W-1:0] tail_sum;
    logic             valid, scan_end, scan_hit, enq_en, dq_issue;
    logic             q_we;
    logic [ID_W-1:0]  q_waddr, q_wdata, q_raddr, q_rdata;
    logic             qt_we;
    logic [ID_W-1:0]  qt_waddr, qt_raddr;
    logic [VW-1:0]    qt_wdata, qt_rdata, qread;

    assign tid_idx  = ID_W'(r_tid);
    assign valid    = (32'(r_tid) < 32'(MAX_THREADS)) && r_exists[tid_idx];
    assign scan_idx = r_scan[ID_W-1:0];
    assign scan_end = (r_scan == MAX_CNT);
    assign scan_hit = !scan_end && ((r_func == rrts_pkg::FN_SPAWN) ? !r_exists[scan_idx] :
                      (r_waiting[scan_idx] && r_exists[scan_idx] && !r_blocked[scan_idx]));
    assign tail_sum = {2'b00, r_head} + {1'b0, r_cnt};
    assign tail     = (tail_sum >= MAX_SUM) ? ID_W'(tail_sum - MAX_SUM) : ID_W'(tail_sum);
    assign head_inc = (r_head == LAST_ID) ? '0 : r_head + ID_W'(1);
    assign rd_inc   = (r_rd_ptr == LAST_ID) ? '0 : r_rd_ptr + ID_W'(1);
    assign wr_inc   = (r_wr_ptr == LAST_ID) ? '0 : r_wr_ptr + ID_W'(1);
    assign dq_issue = (r_k < r_cnt);
    assign c_new    = (r_cnt != '0) ? q_rdata : (!r_exists[r_cur] ? '0 : r_cur);
    assign qread    = r_qv_ok ? qt_rdata : (r_q_is0 ? VW'(1) : '0);

    always_comb begin
        o_stat.func       = r_func;
        o_stat.bad        = !valid;
        o_stat.tid_zero   = (r_tid == '0);
        o_stat.expire     = (r_countdown <= rrts_pkg::QLEN_W'(1));
        o_stat.held       = r_held;
        o_stat.owner_cur  = (r_owner == r_cur);
        o_stat.queued_tid = r_queued[tid_idx];
        o_stat.cur_tid    = (r_cur == tid_idx);
        o_stat.scan_stop  = scan_end || scan_hit;
        o_stat.dq_done    = !dq_issue && !r_pend;
    end

    always_comb begin
        n_func = r_func;       n_tid = r_tid;         n_exists = r_exists;
        n_blocked = r_blocked; n_waiting = r_waiting; n_queued = r_queued;
        n_qvalid = r_qvalid;   n_head = r_head;       n_cnt = r_cnt;
        n_held = r_held;       n_owner = r_owner;     n_cur = r_cur;
        n_total = r_total;     n_countdown = r_countdown;
        n_qlen = r_qlen;       n_scan = r_scan;       n_rd_ptr = r_rd_ptr;
        n_wr_ptr = r_wr_ptr;   n_k = r_k;             n_j = r_j;
        n_pend = r_pend;       n_status = r_status;   n_value = r_value;
        n_sw = r_sw;           n_done = 1'b0;
        enq_en = 1'b0;         enq_id = '0;
        q_we = 1'b0;           q_waddr = r_wr_ptr;    q_wdata = q_rdata;
        q_raddr = r_head;
        qt_we = 1'b0;          qt_waddr = r_cur;      qt_wdata = rrts_pkg::sat_inc(qread);
        qt_raddr = tid_idx;

        if (i_cfg_we) begin
            n_qlen      = i_cfg_wdata;
            n_countdown = rrts_pkg::reload(i_cfg_wdata);
        end

        unique case (i_cmd)
            rrts_pkg::CMD_NONE: begin
            end
            rrts_pkg::CMD_ACCEPT: begin
                n_func = rrts_pkg::t_func'(i_func);
                n_tid  = i_tid;
            end
            rrts_pkg::CMD_DECODE: begin
                n_status = rrts_pkg::ST_OK;
                n_value  = '0;
                n_sw     = 1'b0;
                n_scan   = '0;
                n_rd_ptr = r_head;
                n_wr_ptr = r_head;
                n_k      = '0;
                n_j      = '0;
                n_pend   = 1'b0;
                unique case (r_func)
                    rrts_pkg::FN_TICK: begin
                        if (r_countdown <= rrts_pkg::QLEN_W'(1)) begin
                            n_countdown = rrts_pkg::reload(r_qlen);
                        end else begin
                            n_countdown = r_countdown - rrts_pkg::QLEN_W'(1);
                        end
                    end
                    rrts_pkg::FN_SPAWN: begin
                    end
                    rrts_pkg::FN_TERM: begin
                        priority if (!valid) begin
                            n_status = rrts_pkg::ST_NO_THREAD;
                        end else if (r_tid == '0) begin
                            n_status    = rrts_pkg::ST_SHUTDOWN;
                            n_exists    = '0;
                            n_exists[0] = 1'b1;
                            n_blocked   = '0;
                            n_waiting   = '0;
                            n_queued    = '0;
                            n_qvalid    = '0;
                            n_cnt       = '0;
                            n_held      = 1'b0;
                            n_owner     = '0;
                            n_cur       = '0;
                            n_total     = VW'(1);
                            n_countdown = rrts_pkg::reload(r_qlen);
                        end else begin
                            n_waiting[tid_idx] = 1'b0;
                            n_exists[tid_idx]  = 1'b0;
                            n_blocked[tid_idx] = 1'b0;
                            if (r_held && r_owner == tid_idx) begin
                                n_held  = 1'b0;
                                n_owner = '0;
                            end
                        end
                    end
                    rrts_pkg::FN_BLOCK: begin
                        priority if (!valid) begin
                            n_status = rrts_pkg::ST_NO_THREAD;
                        end else if (r_tid == '0) begin
                            n_status = rrts_pkg::ST_MAIN_BLK;
                        end else begin
                            n_blocked[tid_idx] = 1'b1;
                        end
                    end
                    rrts_pkg::FN_RESUME: begin
                        if (!valid) begin
                            n_status = rrts_pkg::ST_NO_THREAD;
                        end else if (r_blocked[tid_idx]) begin
                            n_blocked[tid_idx] = 1'b0;
                            enq_en = 1'b1;
                            enq_id = tid_idx;
                        end
                    end
                    rrts_pkg::FN_LOCK: begin
                        priority if (!r_held) begin
                            n_held  = 1'b1;
                            n_owner = r_cur;
                        end else if (r_owner == r_cur) begin
                            n_status = rrts_pkg::ST_RELOCK;
                        end else begin
                            n_waiting[r_cur] = 1'b1;
                        end
                    end
                    rrts_pkg::FN_UNLOCK: begin
                        if (!r_held || r_owner != r_cur) begin
                            n_status = rrts_pkg::ST_BAD_UNLK;
                        end else begin
                            n_held  = 1'b0;
                            n_owner = '0;
                        end
                    end
                    rrts_pkg::FN_QUERY: begin
                        if (!valid) begin
                            n_status = rrts_pkg::ST_NO_THREAD;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            rrts_pkg::CMD_SCAN: begin
                priority if (scan_end) begin
                    if (r_func == rrts_pkg::FN_SPAWN) begin
                        n_status = rrts_pkg::ST_FULL;
                    end
                end else if (scan_hit) begin
                    enq_en = 1'b1;
                    enq_id = scan_idx;
                    if (r_func == rrts_pkg::FN_SPAWN) begin
                        n_exists[scan_idx]  = 1'b1;
                        n_blocked[scan_idx] = 1'b0;
                        n_waiting[scan_idx] = 1'b0;
                        n_qvalid[scan_idx]  = 1'b0;
                        n_value             = VW'(scan_idx);
                    end
                end else begin
                    n_scan = r_scan + CNT_W'(1);
                end
            end
            rrts_pkg::CMD_DQ: begin
                q_raddr = r_rd_ptr;
                n_pend  = dq_issue;
                if (dq_issue) begin
                    n_rd_ptr = rd_inc;
                    n_k      = r_k + CNT_W'(1);
                end
                if (r_pend && q_rdata != tid_idx) begin
                    q_we     = 1'b1;
                    n_wr_ptr = wr_inc;
                    n_j      = r_j + CNT_W'(1);
                end
                if (!dq_issue && !r_pend) begin
                    n_cnt             = r_j;
                    n_queued[tid_idx] = 1'b0;
                end
            end
            rrts_pkg::CMD_SW_ENQ: begin
                if (!r_blocked[r_cur] && !r_waiting[r_cur]) begin
                    enq_en = 1'b1;
                    enq_id = r_cur;
                end
            end
            rrts_pkg::CMD_SW_RD: begin
                q_raddr = r_head;
            end
            rrts_pkg::CMD_SW_POP: begin
                qt_raddr = c_new;
                if (r_cnt != '0) begin
                    n_head            = head_inc;
                    n_cnt             = r_cnt - CNT_W'(1);
                    n_queued[q_rdata] = 1'b0;
                end
                n_cur = c_new;
                if (r_waiting[c_new] && !r_held) begin
                    n_held           = 1'b1;
                    n_owner          = c_new;
                    n_waiting[c_new] = 1'b0;
                end
            end
            rrts_pkg::CMD_SW_INC: begin
                qt_we            = 1'b1;
                n_qvalid[r_cur]  = 1'b1;
                n_total          = rrts_pkg::sat_inc(r_total);
                n_sw             = 1'b1;
            end
            rrts_pkg::CMD_QDATA: begin
                n_value = qread;
            end
            rrts_pkg::CMD_FINISH: begin
                n_done = 1'b1;
            end
            default: begin
            end
        endcase

        if (enq_en && !r_queued[enq_id]) begin
            q_we             = 1'b1;
            q_waddr          = tail;
            q_wdata          = enq_id;
            n_queued[enq_id] = 1'b1;
            n_cnt            = r_cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exists    <= MAX_THREADS'(1);
            r_blocked   <= '0;
            r_waiting   <= '0;
            r_queued    <= '0;
            r_qvalid    <= '0;
            r_head      <= '0;
            r_cnt       <= '0;
            r_held      <= 1'b0;
            r_owner     <= '0;
            r_cur       <= '0;
            r_total     <= VW'(1);
            r_countdown <= rrts_pkg::DEF_QUANTUM;
            r_qlen      <= rrts_pkg::DEF_QUANTUM;
            r_scan      <= '0;
            r_k         <= '0;
            r_pend      <= 1'b0;
            r_done      <= 1'b0;
        end else begin
            r_exists    <= n_exists;
            r_blocked   <= n_blocked;
            r_waiting   <= n_waiting;
            r_queued    <= n_queued;
            r_qvalid    <= n_qvalid;
            r_head      <= n_head;
            r_cnt       <= n_cnt;
            r_held      <= n_held;
            r_owner     <= n_owner;
            r_cur       <= n_cur;
            r_total     <= n_total;
            r_countdown <= n_countdown;
            r_qlen      <= n_qlen;
            r_scan      <= n_scan;
            r_k         <= n_k;
            r_pend      <= n_pend;
            r_done      <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func   <= n_func;
        r_tid    <= n_tid;
        r_rd_ptr <= n_rd_ptr;
        r_wr_ptr <= n_wr_ptr;
        r_j      <= n_j;
        r_status <= n_status;
        r_value  <= n_value;
        r_sw     <= n_sw;
        r_qv_ok  <= r_qvalid[qt_raddr];
        r_q_is0  <= (qt_raddr == '0);
    end

    rrts_ram #(.WIDTH(ID_W), .DEPTH(MAX_THREADS)) u_ready_q (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (q_waddr),
        .i_wdata (q_wdata),
        .i_raddr (q_raddr),
        .o_rdata (q_rdata)
    );

    rrts_ram #(.WIDTH(VW), .DEPTH(MAX_THREADS)) u_quanta (
        .i_clk   (i_clk),
        .i_we    (qt_we),
        .i_waddr (qt_waddr),
        .i_wdata (qt_wdata),
        .i_raddr (qt_raddr),
        .o_rdata (qt_rdata)
    );

    assign o_status       = r_status;
    assign o_value        = r_value;
    assign o_running_id   = rrts_pkg::TID_W'(r_cur);
    assign o_total_quanta = r_total;
    assign o_switched     = r_sw;
    assign o_done         = r_done;

`ifndef SYNTH
    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_queued) == int'(r_cnt))
        else $error("ready count differs from queued flags");
    a_main_exists: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_exists[0])
        else $error("main thread slot lost");
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("result strobe longer than one cycle");
`endif

endmodule

// File: hw/rtl/round_robin_thread_scheduler.sv
// Top level of the round-robin thread scheduler with one mutex.
// Each command is decoded, then finished with the result strobe; a switch adds the enqueue,
// read, pop and increment states (terminate skips enqueue). Ready queue removal first walks the
// queue; free slot and waiter scans test one slot per cycle. Commands are handled one at a time.
// Results are strobed for one cycle on o_done and cannot be stalled by the receiver.
// Synchronous active-low reset restores slot zero as the sole running thread, quantum 1000.
module round_robin_thread_scheduler #(
    parameter int MAX_THREADS = rrts_pkg::DEF_MAX_THREADS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [rrts_pkg::FUNC_W-1:0]   i_func,
    input  logic [rrts_pkg::TID_W-1:0]    i_target_thread,
    input  logic                          i_cfg_we,
    input  logic [rrts_pkg::QLEN_W-1:0]   i_cfg_wdata,
    output logic                          o_done,
    output logic [rrts_pkg::STATUS_W-1:0] o_status,
    output logic [rrts_pkg::VALUE_W-1:0]  o_value,
    output logic [rrts_pkg::TID_W-1:0]    o_running_id,
    output logic [rrts_pkg::VALUE_W-1:0]  o_total_quanta,
    output logic                          o_switched
);

    rrts_pkg::t_cmd       cmd;
    rrts_pkg::t_dp_status stat;

    rrts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    rrts_datapath #(.MAX_THREADS(MAX_THREADS)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_func         (i_func),
        .i_tid          (i_target_thread),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_status       (o_status),
        .o_value        (o_value),
        .o_running_id   (o_running_id),
        .o_total_quanta (o_total_quanta),
        .o_switched     (o_switched),
        .o_done         (o_done)
    );

endmodule

// File: tb/sv/tb.sv
// Testbench for the round-robin thread scheduler: queue-fed driver, monitor and scoreboard.
`timescale 1ns / 100ps

module tb;
    import rrts_pkg::*;

    typedef struct packed {
        t_status          status;
        logic [31:0]      value;
        logic [3:0]       running;
        logic [31:0]      total;
        logic             switched;
    } t_sched_result;

    typedef struct packed {
        t_func       func;
        logic [3:0]  tid;
    } t_sched_cmd;

    logic              i_clk;
    logic              i_rst_n;
    logic              start = 1'b0;
    logic              busy;
    logic [2:0]        i_func = '0;
    logic [3:0]        i_target_thread = '0;
    logic              i_cfg_we;
    logic [19:0]       i_cfg_wdata;
    logic              o_done;
    logic [2:0]        o_status;
    logic [31:0]       o_value;
    logic [3:0]        o_running_id;
    logic [31:0]       o_total_quanta;
    logic              o_switched;

    round_robin_thread_scheduler u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_func          (i_func),
        .i_target_thread (i_target_thread),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_value         (o_value),
        .o_running_id    (o_running_id),
        .o_total_quanta  (o_total_quanta),
        .o_switched      (o_switched)
    );

    // Scheduler shadow state.
    logic [3:0]   ready_q[$];
    logic         sh_exists  [16];
    logic         sh_blocked [16];
    logic         sh_waiting [16];
    logic [31:0]  sh_quanta  [16];
    logic         sh_held;
    logic [3:0]   sh_owner;
    logic [3:0]   sh_current;
    logic [31:0]  sh_total;
    logic [19:0]  sh_qlen;
    logic [19:0]  sh_countdown;

    t_sched_cmd     pending_cmds[$];
    t_sched_result  expected_results[$];
    int unsigned    gap = 0;
    logic           took = 1'b0;
    int             mismatches = 0;
    int             results_seen = 0;
    int             switches_seen = 0;
    int             func_count[8];
    int unsigned    cycles = 0;

    function automatic logic [19:0] reload_len();
        return (sh_qlen == '0) ? 20'd1 : sh_qlen;
    endfunction

    function automatic logic [31:0] sat_up(logic [31:0] v);
        return (v == '1) ? v : v + 32'd1;
    endfunction

    function automatic void ready_push(logic [3:0] id);
        foreach (ready_q[i]) if (ready_q[i] == id) return;
        if (ready_q.size() < 16) ready_q.push_back(id);
    endfunction

    function automatic void ready_remove(logic [3:0] id);
        logic [3:0] kept[$];
        foreach (ready_q[i]) if (ready_q[i] != id) kept.push_back(ready_q[i]);
        ready_q = kept;
    endfunction

    function automatic void switch_thread(logic self_gone);
        logic [3:0] c;
        c = sh_current;
        if (!self_gone && !sh_blocked[c] && !sh_waiting[c]) ready_push(c);
        if (ready_q.size() > 0) c = ready_q.pop_front();
        else if (!sh_exists[c]) c = 4'd0;
        sh_current = c;
        if (sh_waiting[c] && !sh_held) begin
            sh_held = 1'b1;
            sh_owner = c;
            sh_waiting[c] = 1'b0;
        end
        sh_quanta[c] = sat_up(sh_quanta[c]);
        sh_total = sat_up(sh_total);
    endfunction

    function automatic void sched_clear();
        ready_q.delete();
        for (int i = 0; i < 16; i++) begin
            sh_exists[i] = (i == 0);
            sh_blocked[i] = 1'b0;
            sh_waiting[i] = 1'b0;
            sh_quanta[i] = (i == 0) ? 32'd1 : 32'd0;
        end
        sh_held = 1'b0;
        sh_owner = 4'd0;
        sh_current = 4'd0;
        sh_total = 32'd1;
        sh_countdown = reload_len();
    endfunction

    function automatic t_sched_result schedule_cmd(t_func f, logic [3:0] tid);
        t_sched_result r;
        logic ok;
        int i;
        r = '0;
        r.status = ST_OK;
        ok = sh_exists[tid];
        case (f)
            FN_TICK: begin
                if (sh_countdown <= 20'd1) begin
                    sh_countdown = reload_len();
                    switch_thread(1'b0);
                    r.switched = 1'b1;
                end else begin
                    sh_countdown = sh_countdown - 20'd1;
                end
            end
            FN_SPAWN: begin
                for (i = 0; i < 16 && sh_exists[i]; i++) ;
                if (i == 16) begin
                    r.status = ST_FULL;
                end else begin
                    sh_exists[i] = 1'b1;
                    sh_blocked[i] = 1'b0;
                    sh_waiting[i] = 1'b0;
                    sh_quanta[i] = 32'd0;
                    ready_push(4'(i));
                    r.value = 32'(i);
                end
            end
            FN_TERM: begin
                if (!ok) begin
                    r.status = ST_NO_THREAD;
                end else if (tid == 4'd0) begin
                    sched_clear();
                    r.status = ST_SHUTDOWN;
                end else begin
                    ready_remove(tid);
                    sh_waiting[tid] = 1'b0;
                    if (sh_held && sh_owner == tid) begin
                        sh_held = 1'b0;
                        sh_owner = 4'd0;
                    end
                    sh_exists[tid] = 1'b0;
                    sh_blocked[tid] = 1'b0;
                    if (sh_current == tid) begin
                        switch_thread(1'b1);
                        r.switched = 1'b1;
                    end
                end
            end
            FN_BLOCK: begin
                if (!ok) begin
                    r.status = ST_NO_THREAD;
                end else if (tid == 4'd0) begin
                    r.status = ST_MAIN_BLK;
                end else begin
                    sh_blocked[tid] = 1'b1;
                    ready_remove(tid);
                    if (sh_current == tid) begin
                        switch_thread(1'b0);
                        r.switched = 1'b1;
                    end
                end
            end
            FN_RESUME: begin
                if (!ok) begin
                    r.status = ST_NO_THREAD;
                end else if (sh_blocked[tid]) begin
                    sh_blocked[tid] = 1'b0;
                    ready_push(tid);
                end
            end
            FN_LOCK: begin
                if (sh_held) begin
                    if (sh_owner == sh_current) begin
                        r.status = ST_RELOCK;
                    end else begin
                        sh_waiting[sh_current] = 1'b1;
                        switch_thread(1'b0);
                        r.switched = 1'b1;
                    end
                end else begin
                    sh_held = 1'b1;
                    sh_owner = sh_current;
                end
            end
            FN_UNLOCK: begin
                if (!sh_held || sh_owner != sh_current) begin
                    r.status = ST_BAD_UNLK;
                end else begin
                    sh_held = 1'b0;
                    sh_owner = 4'd0;
                    for (i = 0; i < 16; i++) begin
                        if (sh_waiting[i] && sh_exists[i] && !sh_blocked[i]) begin
                            ready_push(4'(i));
                            break;
                        end
                    end
                end
            end
            default: begin
                if (!ok) r.status = ST_NO_THREAD;
                else r.value = sh_quanta[tid];
            end
        endcase
        r.running = sh_current;
        r.total = sh_total;
        return r;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Monitor and scoreboard.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        took <= i_rst_n && start && !busy;
        if (!i_rst_n) begin
            sh_qlen = DEF_QUANTUM;
            sched_clear();
        end else begin
            if (i_cfg_we) begin
                sh_qlen = i_cfg_wdata;
                sh_countdown = reload_len();
            end
            if (start && !busy) begin
                expected_results.push_back(schedule_cmd(t_func'(i_func), i_target_thread));
                func_count[i_func]++;
            end
            if (o_done) begin
                t_sched_result want, got;
                got = {t_status'(o_status), o_value, o_running_id, o_total_quanta, o_switched};
                results_seen++;
                if (o_switched) switches_seen++;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("Unexpected transaction: %p", got);
                end else begin
                    want = expected_results.pop_front();
                    if (want != got) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Mismatch: expected %p, actual %p", want, got);
                    end
                end
            end
        end
    end

    // Command driver.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start) begin
            if (took) start <= 1'b0;
        end else if (gap != 0) begin
            gap <= gap - 1;
        end else if (pending_cmds.size() > 0) begin
            t_sched_cmd c;
            c = pending_cmds.pop_front();
            i_func <= c.func;
            i_target_thread <= c.tid;
            start <= 1'b1;
            gap <= $urandom_range(0, 17);
        end
    end

    always @(posedge i_clk) begin
        if (cycles > 1000000) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic add_cmd(t_func f, int tid);
        pending_cmds.push_back('{f, 4'(tid)});
    endtask

    task automatic drain();
        while (pending_cmds.size() > 0 || start || took || expected_results.size() > 0)
            @(negedge i_clk);
        repeat (50) @(negedge i_clk);
    endtask

    task automatic write_quantum(logic [19:0] len);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= len;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_cmds(int n);
        int r, t;
        t_func f;
        repeat (n) begin
            r = $urandom_range(0, 99);
            t = $urandom_range(0, 15);
            if (r < 30) f = FN_TICK;
            else if (r < 45) f = FN_SPAWN;
            else if (r < 55) f = FN_TERM;
            else if (r < 63) f = FN_BLOCK;
            else if (r < 71) f = FN_RESUME;
            else if (r < 81) f = FN_LOCK;
            else if (r < 91) f = FN_UNLOCK;
            else f = FN_QUERY;
            if (f == FN_TERM && t == 0 && $urandom_range(0, 9) != 0) t = $urandom_range(1, 15);
            add_cmd(f, t);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        add_cmd(FN_TICK, 0);
        repeat (16) add_cmd(FN_SPAWN, 0);
        add_cmd(FN_QUERY, 15);
        add_cmd(FN_BLOCK, 0);
        add_cmd(FN_BLOCK, 3);
        add_cmd(FN_RESUME, 3);
        add_cmd(FN_LOCK, 0);
        add_cmd(FN_LOCK, 0);
        add_cmd(FN_UNLOCK, 0);
        add_cmd(FN_UNLOCK, 0);
        add_cmd(FN_TERM, 5);
        add_cmd(FN_TERM, 0);
        add_cmd(FN_QUERY, 9);
        add_cmd(FN_RESUME, 9);

        write_quantum(20'd1);
        random_cmds(320);
        write_quantum(20'd0);
        random_cmds(320);
        write_quantum(20'd3);
        random_cmds(320);
        write_quantum(20'hFFFFF);
        random_cmds(300);
        write_quantum(20'd2);
        random_cmds(320);
        write_quantum(20'd7);
        random_cmds(320);
        drain();

        $display("Run covered %0d results, %0d with a thread switch, quantum lengths 0 to max.",
                 results_seen, switches_seen);
        $display("Commands per function: %p", func_count);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/rrts_pkg.sv
hw/rtl/rrts_ram.sv
hw/rtl/rrts_ctrl.sv
hw/rtl/rrts_datapath.sv
hw/rtl/round_robin_thread_scheduler.sv
tb/sv/tb.sv
